FILE: rtl/core/two_level_lru_cache_model_top_defines.svh
// Assertion macros for the two-level LRU cache model.
// Included by the top level; depends on clk and rst in the including scope.
`ifndef TWO_LEVEL_LRU_CACHE_MODEL_TOP_DEFINES_SVH
`define TWO_LEVEL_LRU_CACHE_MODEL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TLLC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define TLLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TLLC_ASSERT_IMPL(lbl, ante, cons)
`define TLLC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/tllc_pkg.sv
// Shared types, constants and way-selection functions for the cache model.
// Used by the top level; depends on nothing else.
`timescale 1ns / 1ps
package tllc_pkg;
  localparam int L1_SETS = 64;
  localparam int L2_SETS = 256;
  localparam int L1_SET_W = 6;
  localparam int L2_SET_W = 8;
  localparam int BLK_W = 32;
  localparam int GW = 8;

  localparam logic [2:0] REG_ALLOC_MODE = 3'd0;
  localparam logic [2:0] REG_BLOCK_BITS = 3'd1;
  localparam logic [2:0] REG_L1_SET_BITS = 3'd2;
  localparam logic [2:0] REG_L1_WAYS_USED = 3'd3;
  localparam logic [2:0] REG_L2_SET_BITS = 3'd4;
  localparam logic [2:0] REG_L2_WAYS_USED = 3'd5;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic valid;
    logic dirty;
  } line_t;

  typedef struct packed {
    line_t [3:0] lines;
    logic [3:0][1:0] rank;
  } l1_row_t;

  typedef struct packed {
    line_t [GW-1:0] lines;
    logic [GW-1:0][2:0] rank;
  } row_t;

  typedef struct packed {
    logic hit;
    logic [2:0] way;
  } find_t;

  function automatic row_t l1_expand(l1_row_t r);
    row_t o;
    o = '0;
    for (int i = 0; i < 4; i++) begin
      o.lines[i] = r.lines[i];
      o.rank[i] = {1'b0, r.rank[i]};
    end
    return o;
  endfunction

  function automatic l1_row_t l1_pack(row_t r);
    l1_row_t o;
    for (int i = 0; i < 4; i++) begin
      o.lines[i] = r.lines[i];
      o.rank[i] = r.rank[i][1:0];
    end
    return o;
  endfunction

  function automatic logic [3:0] l1_eff_ways(logic [2:0] w);
    if (w == 3'd0) return 4'd1;
    if (w > 3'd4) return 4'd4;
    return {1'b0, w};
  endfunction

  function automatic logic [3:0] l2_eff_ways(logic [3:0] w);
    if (w == 4'd0) return 4'd1;
    if (w > 4'd8) return 4'd8;
    return w;
  endfunction

  function automatic logic [L1_SET_W-1:0] l1_set(logic [BLK_W-1:0] blk, logic [2:0] sb);
    logic [L1_SET_W-1:0] m;
    m = (sb >= 3'd6) ? '1 : 6'((7'd1 << sb) - 7'd1);
    return blk[L1_SET_W-1:0] & m;
  endfunction

  function automatic logic [L2_SET_W-1:0] l2_set(logic [BLK_W-1:0] blk, logic [3:0] sb);
    logic [L2_SET_W-1:0] m;
    m = (sb >= 4'd8) ? '1 : 8'((9'd1 << sb) - 9'd1);
    return blk[L2_SET_W-1:0] & m;
  endfunction

  function automatic find_t find_way(row_t r, logic [BLK_W-1:0] blk, logic [3:0] n);
    find_t f;
    f = '0;
    for (int i = 0; i < GW; i++) begin
      if (!f.hit && 4'(i) < n && r.lines[i].valid && r.lines[i].blk == blk) begin
        f.hit = 1'b1;
        f.way = 3'(i);
      end
    end
    return f;
  endfunction

  function automatic logic [2:0] pick_victim(row_t r, logic [3:0] n);
    logic found;
    logic [2:0] v;
    logic [2:0] best;
    found = 1'b0;
    v = '0;
    best = '0;
    for (int i = 0; i < GW; i++) begin
      if (!found && 4'(i) < n && !r.lines[i].valid) begin
        found = 1'b1;
        v = 3'(i);
      end
    end
    for (int i = 1; i < GW; i++) begin
      if (4'(i) < n && r.rank[i] > r.rank[best]) best = 3'(i);
    end
    return found ? v : best;
  endfunction

  function automatic row_t touch(row_t r, logic [2:0] w, logic [2:0] old, logic [3:0] n);
    row_t o;
    o = r;
    for (int i = 0; i < GW; i++) begin
      if (4'(i) < n && 3'(i) != w && r.lines[i].valid && r.rank[i] < old &&
          ({1'b0, r.rank[i]} + 4'd1) < n) begin
        o.rank[i] = r.rank[i] + 3'd1;
      end
    end
    o.rank[w] = '0;
    return o;
  endfunction

  function automatic row_t fill(row_t r, logic [BLK_W-1:0] blk, logic [2:0] w,
                                logic dirty, logic [3:0] n);
    row_t o;
    logic [2:0] old;
    logic [3:0] nm1;
    nm1 = n - 4'd1;
    old = r.lines[w].valid ? r.rank[w] : nm1[2:0];
    o = r;
    o.lines[w].blk = blk;
    o.lines[w].valid = 1'b1;
    o.lines[w].dirty = dirty;
    return touch(o, w, old, n);
  endfunction
endpackage

FILE: rtl/core/tllc_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the tag and LRU rows of both cache levels; no dependencies.
`timescale 1ns / 1ps
module tllc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/core/two_level_lru_cache_model_top.sv
// Top level of the two-level write-back LRU cache model: control sequencer and row memories.
// Depends on tllc_pkg, tllc_ram and the assertion macro header.
//
// Usage: an access (operation, address) is transferred when in_valid is high and
// in_stall is low. One result transfer follows per access on the output channel,
// taken when out_valid is high and out_stall is low. Configuration registers are
// written through cfg_write, cfg_index and cfg_data while the block is idle.
// The result is registered after the states ST_RD, ST_L1 and ST_PUSH on an L1 hit
// or a write-around miss, with ST_FILL before ST_PUSH on an L1 miss that allocates,
// and with ST_WB and ST_RD2 before ST_FILL when a dirty L1 victim is written back.
// ST_PUSH returns to ST_IDLE, where the next access is taken. The states follow
// from the registered reads of the L1 and L2 row memories and the read-modify-write of
// each row. One access is in flight at a time; a finished result waits in the output
// register while the next access is taken, and the block holds a further result
// until the receiver stops stalling. Reset clears per-row valid bits of both
// levels at once, so no clearing pass is needed, and restores register defaults.
`timescale 1ns / 1ps
`include "two_level_lru_cache_model_top_defines.svh"
module two_level_lru_cache_model_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        l1_hit,
  output logic        l2_accessed,
  output logic        l2_hit,
  output logic        memory_accessed,
  output logic        l1_victim_written_back,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_L1, ST_WB, ST_RD2, ST_FILL, ST_PUSH
  } state_t;

  state_t state;
  logic alloc_on_wmiss;
  logic [3:0] block_bits;
  logic [2:0] l1_set_bits;
  logic [2:0] l1_ways_used;
  logic [3:0] l2_set_bits;
  logic [3:0] l2_ways_used;

  logic op_q;
  logic [tllc_pkg::BLK_W-1:0] blk_q;
  logic [tllc_pkg::BLK_W-1:0] vblk_q;
  tllc_pkg::row_t row1_q;
  logic [2:0] v1_q;
  logic res_l1hit, res_acc2, res_hit2, res_mem, res_wb;
  logic [tllc_pkg::L1_SETS-1:0] rv1;
  logic [tllc_pkg::L2_SETS-1:0] rv2;
  logic rv1_q, rv2_q;

  logic l1_re, l1_we, l2_re, l2_we;
  logic [tllc_pkg::L1_SET_W-1:0] l1_raddr, l1_waddr;
  logic [tllc_pkg::L2_SET_W-1:0] l2_raddr, l2_waddr;
  tllc_pkg::l1_row_t l1_rdata, l1_wdata;
  tllc_pkg::row_t l2_rdata, l2_wdata;

  logic [3:0] n1, n2;
  logic [tllc_pkg::L1_SET_W-1:0] set1;
  logic [tllc_pkg::L2_SET_W-1:0] set2, vset2, vset2_now;
  tllc_pkg::row_t row1_rd, row2_rd, hit_row1, l2_mod;
  tllc_pkg::find_t f1, f2, fv;
  logic [2:0] vic1;
  tllc_pkg::line_t vline;
  logic alloc;
  logic out_beyond_l1;
  state_t state_next;

  assign n1 = tllc_pkg::l1_eff_ways(l1_ways_used);
  assign n2 = tllc_pkg::l2_eff_ways(l2_ways_used);
  assign set1 = tllc_pkg::l1_set(blk_q, l1_set_bits);
  assign set2 = tllc_pkg::l2_set(blk_q, l2_set_bits);
  assign vset2 = tllc_pkg::l2_set(vblk_q, l2_set_bits);
  assign row1_rd = rv1_q ? tllc_pkg::l1_expand(l1_rdata) : '0;
  assign row2_rd = rv2_q ? l2_rdata : '0;
  assign f1 = tllc_pkg::find_way(row1_rd, blk_q, n1);
  assign f2 = tllc_pkg::find_way(row2_rd, blk_q, n2);
  assign fv = tllc_pkg::find_way(row2_rd, vblk_q, n2);
  assign vic1 = tllc_pkg::pick_victim(row1_rd, n1);
  assign vline = row1_rd.lines[vic1];
  assign vset2_now = tllc_pkg::l2_set(vline.blk, l2_set_bits);
  assign alloc = (op_q != tllc_pkg::OP_WRITE) || alloc_on_wmiss;
  assign in_stall = (state != ST_IDLE);
  assign out_beyond_l1 = l2_accessed | l2_hit | memory_accessed | l1_victim_written_back;

  always_comb begin
    hit_row1 = tllc_pkg::touch(row1_rd, f1.way, row1_rd.rank[f1.way], n1);
    if (op_q == tllc_pkg::OP_WRITE) begin
      hit_row1.lines[f1.way].dirty = 1'b1;
    end
  end

  always_comb begin
    l1_re = 1'b0;
    l1_we = 1'b0;
    l2_re = 1'b0;
    l2_we = 1'b0;
    l1_raddr = set1;
    l1_waddr = set1;
    l2_raddr = set2;
    l2_waddr = set2;
    l1_wdata = tllc_pkg::l1_pack(hit_row1);
    l2_mod = row2_rd;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_RD;
      end
      ST_RD: begin
        l1_re = 1'b1;
        l2_re = 1'b1;
        state_next = ST_L1;
      end
      ST_L1: begin
        if (f1.hit) begin
          l1_we = 1'b1;
          state_next = ST_PUSH;
        end else if (!alloc) begin
          l2_mod.lines[f2.way].dirty = 1'b1;
          l2_mod = tllc_pkg::touch(l2_mod, f2.way, row2_rd.rank[f2.way], n2);
          l2_we = f2.hit;
          state_next = ST_PUSH;
        end else if (vline.valid && vline.dirty) begin
          l2_re = 1'b1;
          l2_raddr = vset2_now;
          state_next = ST_WB;
        end else begin
          state_next = ST_FILL;
        end
      end
      ST_WB: begin
        l2_mod.lines[fv.way].dirty = 1'b1;
        l2_mod = tllc_pkg::touch(l2_mod, fv.way, row2_rd.rank[fv.way], n2);
        l2_we = fv.hit;
        l2_waddr = vset2;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        l2_re = 1'b1;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        if (res_hit2) begin
          l2_mod = tllc_pkg::touch(row2_rd, f2.way, row2_rd.rank[f2.way], n2);
        end else begin
          l2_mod = tllc_pkg::fill(row2_rd, blk_q, tllc_pkg::pick_victim(row2_rd, n2),
                                  1'b0, n2);
        end
        l2_we = 1'b1;
        l1_we = 1'b1;
        l1_wdata = tllc_pkg::l1_pack(tllc_pkg::fill(row1_q, blk_q, v1_q, op_q, n1));
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    l2_wdata = l2_mod;
  end

  tllc_ram #(.WIDTH($bits(tllc_pkg::l1_row_t)), .DEPTH(tllc_pkg::L1_SETS)) u_l1_ram (
    .clk(clk), .re(l1_re), .raddr(l1_raddr), .rdata(l1_rdata),
    .we(l1_we), .waddr(l1_waddr), .wdata(l1_wdata)
  );

  tllc_ram #(.WIDTH($bits(tllc_pkg::row_t)), .DEPTH(tllc_pkg::L2_SETS)) u_l2_ram (
    .clk(clk), .re(l2_re), .raddr(l2_raddr), .rdata(l2_rdata),
    .we(l2_we), .waddr(l2_waddr), .wdata(l2_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      rv1 <= '0;
      rv2 <= '0;
      alloc_on_wmiss <= 1'b1;
      block_bits <= 4'd5;
      l1_set_bits <= 3'd6;
      l1_ways_used <= 3'd4;
      l2_set_bits <= 4'd8;
      l2_ways_used <= 4'd8;
    end else begin
      state <= state_next;
      if (state == ST_PUSH && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          tllc_pkg::REG_ALLOC_MODE: alloc_on_wmiss <= cfg_data[0];
          tllc_pkg::REG_BLOCK_BITS: block_bits <= cfg_data;
          tllc_pkg::REG_L1_SET_BITS: l1_set_bits <= cfg_data[2:0];
          tllc_pkg::REG_L1_WAYS_USED: l1_ways_used <= cfg_data[2:0];
          tllc_pkg::REG_L2_SET_BITS: l2_set_bits <= cfg_data;
          tllc_pkg::REG_L2_WAYS_USED: l2_ways_used <= cfg_data;
          default: ;
        endcase
      end
      if (l1_re) rv1_q <= rv1[l1_raddr];
      if (l2_re) rv2_q <= rv2[l2_raddr];
      if (l1_we) rv1[l1_waddr] <= 1'b1;
      if (l2_we) rv2[l2_waddr] <= 1'b1;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q <= operation;
            blk_q <= address >> block_bits;
          end
        end
        ST_L1: begin
          res_l1hit <= f1.hit;
          res_acc2 <= !f1.hit;
          res_hit2 <= !f1.hit && f2.hit;
          res_mem <= !f1.hit && !f2.hit;
          res_wb <= 1'b0;
          row1_q <= row1_rd;
          v1_q <= vic1;
          vblk_q <= vline.blk;
        end
        ST_WB: begin
          if (fv.hit) res_wb <= 1'b1;
          else res_mem <= 1'b1;
        end
        ST_PUSH: begin
          if (!out_valid || !out_stall) begin
            l1_hit <= res_l1hit;
            l2_accessed <= res_acc2;
            l2_hit <= res_hit2;
            memory_accessed <= res_mem;
            l1_victim_written_back <= res_wb;
          end
        end
        default: ;
      endcase
    end
  end

  `TLLC_ASSERT_IMPL(a_l1hit_alone, out_valid && l1_hit, !out_beyond_l1)
  `TLLC_ASSERT_IMPL(a_l2hit_needs_lookup, out_valid && l2_hit, l2_accessed)
  `TLLC_ASSERT_IMPL(a_wb_needs_miss, out_valid && l1_victim_written_back, l2_accessed && !l1_hit)
  `TLLC_ASSERT_NEXT(a_accept_reads, in_valid && !in_stall, state == ST_RD)
endmodule

FILE: bench/cache_access_checker.sv
// Checker for the two-level LRU cache model: watches the access and result channels,
// predicts each result with its own cache hierarchy model and compares field by field.
// Depends on tllc_pkg for register index names.
`timescale 1ns / 1ps
module cache_access_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        operation,
  input  logic [31:0] address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        l1_hit,
  input  logic        l2_accessed,
  input  logic        l2_hit,
  input  logic        memory_accessed,
  input  logic        l1_victim_written_back,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int          error_count,
  output int          pending_count
);
  typedef struct packed {
    logic l1_hit;
    logic l2_accessed;
    logic l2_hit;
    logic memory_accessed;
    logic victim_wb;
  } outcome_t;

  typedef struct {
    logic [31:0] blk;
    logic        valid;
    logic        dirty;
  } way_t;

  way_t     l1_way [64][4];
  int       l1_age [64][4];
  way_t     l2_way [256][8];
  int       l2_age [256][8];
  logic     wr_alloc;
  int       blk_shift, l1_sb, l1_wu, l2_sb, l2_wu;
  outcome_t expected_q[$];

  assign pending_count = expected_q.size();

  function automatic int used_ways(bit second);
    int w;
    w = second ? l2_wu : l1_wu;
    if (w < 1) w = 1;
    if (w > (second ? 8 : 4)) w = second ? 8 : 4;
    return w;
  endfunction

  function automatic int set_of(bit second, logic [31:0] blk);
    logic [63:0] s;
    int sb;
    sb = second ? l2_sb : l1_sb;
    s = {32'd0, blk} & ((64'd1 << sb) - 64'd1);
    return int'(s % (second ? 256 : 64));
  endfunction

  function automatic int lookup(bit second, logic [31:0] blk);
    int s;
    s = set_of(second, blk);
    for (int i = 0; i < used_ways(second); i++) begin
      if (second ? (l2_way[s][i].valid && l2_way[s][i].blk == blk)
                 : (l1_way[s][i].valid && l1_way[s][i].blk == blk)) return i;
    end
    return -1;
  endfunction

  function automatic int victim_of(bit second, logic [31:0] blk);
    int s, n, b;
    s = set_of(second, blk);
    n = used_ways(second);
    b = 0;
    for (int i = 0; i < n; i++)
      if (!(second ? l2_way[s][i].valid : l1_way[s][i].valid)) return i;
    for (int i = 1; i < n; i++)
      if ((second ? l2_age[s][i] : l1_age[s][i]) > (second ? l2_age[s][b] : l1_age[s][b]))
        b = i;
    return b;
  endfunction

  task automatic promote(bit second, logic [31:0] blk, int w, int old);
    int s, n;
    s = set_of(second, blk);
    n = used_ways(second);
    for (int i = 0; i < n; i++) begin
      if (i == w) continue;
      if (second) begin
        if (l2_way[s][i].valid && l2_age[s][i] < old && l2_age[s][i] + 1 < n)
          l2_age[s][i]++;
      end else begin
        if (l1_way[s][i].valid && l1_age[s][i] < old && l1_age[s][i] + 1 < n)
          l1_age[s][i]++;
      end
    end
    if (second) l2_age[s][w] = 0;
    else l1_age[s][w] = 0;
  endtask

  task automatic promote_hit(bit second, logic [31:0] blk, int w);
    int s;
    s = set_of(second, blk);
    promote(second, blk, w, second ? l2_age[s][w] : l1_age[s][w]);
  endtask

  task automatic install(bit second, logic [31:0] blk, int w, logic dirty);
    int s, old;
    s = set_of(second, blk);
    if (second) begin
      old = l2_way[s][w].valid ? l2_age[s][w] : used_ways(1) - 1;
      l2_way[s][w] = '{blk, 1'b1, dirty};
    end else begin
      old = l1_way[s][w].valid ? l1_age[s][w] : used_ways(0) - 1;
      l1_way[s][w] = '{blk, 1'b1, dirty};
    end
    promote(second, blk, w, old);
  endtask

  task automatic predict_access(logic wr, logic [31:0] addr);
    outcome_t o;
    logic [31:0] blk;
    int w, w2, v, s1, wv;
    way_t old;
    o = '0;
    blk = addr >> blk_shift;
    w = lookup(0, blk);
    if (w >= 0) begin
      o.l1_hit = 1'b1;
      promote_hit(0, blk, w);
      if (wr) l1_way[set_of(0, blk)][w].dirty = 1'b1;
    end else begin
      w2 = lookup(1, blk);
      o.l2_accessed = 1'b1;
      o.l2_hit = (w2 >= 0);
      if (w2 < 0) o.memory_accessed = 1'b1;
      if (!wr || wr_alloc) begin
        v = victim_of(0, blk);
        s1 = set_of(0, blk);
        old = l1_way[s1][v];
        if (old.valid && old.dirty) begin
          wv = lookup(1, old.blk);
          if (wv >= 0) begin
            l2_way[set_of(1, old.blk)][wv].dirty = 1'b1;
            promote_hit(1, old.blk, wv);
            o.victim_wb = 1'b1;
          end else begin
            o.memory_accessed = 1'b1;
          end
        end
        if (w2 >= 0) begin
          w2 = lookup(1, blk);
          if (w2 >= 0) promote_hit(1, blk, w2);
        end else begin
          install(1, blk, victim_of(1, blk), 1'b0);
        end
        install(0, blk, v, wr);
      end else if (w2 >= 0) begin
        l2_way[set_of(1, blk)][w2].dirty = 1'b1;
        promote_hit(1, blk, w2);
      end
    end
    expected_q.insert(expected_q.size(), o);
  endtask

  task automatic report_mismatch(string what, logic got, logic want);
    $display("mismatch at %0t: %s got %0b expected %0b", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (l1_way[s, i]) begin
        l1_way[s][i] = '{32'd0, 1'b0, 1'b0};
        l1_age[s][i] = 0;
      end
      foreach (l2_way[s, i]) begin
        l2_way[s][i] = '{32'd0, 1'b0, 1'b0};
        l2_age[s][i] = 0;
      end
      wr_alloc = 1'b1;
      blk_shift = 5;
      l1_sb = 6;
      l1_wu = 4;
      l2_sb = 8;
      l2_wu = 8;
      expected_q.delete();
      error_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          tllc_pkg::REG_ALLOC_MODE:   wr_alloc = cfg_data[0];
          tllc_pkg::REG_BLOCK_BITS:   blk_shift = int'(cfg_data);
          tllc_pkg::REG_L1_SET_BITS:  l1_sb = int'(cfg_data[2:0]);
          tllc_pkg::REG_L1_WAYS_USED: l1_wu = int'(cfg_data[2:0]);
          tllc_pkg::REG_L2_SET_BITS:  l2_sb = int'(cfg_data);
          tllc_pkg::REG_L2_WAYS_USED: l2_wu = int'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_access(operation, address);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer", 1'b1, 1'b0);
        end else begin
          outcome_t e;
          e = expected_q.pop_front();
          if (l1_hit !== e.l1_hit) report_mismatch("l1_hit", l1_hit, e.l1_hit);
          if (l2_accessed !== e.l2_accessed)
            report_mismatch("l2_accessed", l2_accessed, e.l2_accessed);
          if (l2_hit !== e.l2_hit) report_mismatch("l2_hit", l2_hit, e.l2_hit);
          if (memory_accessed !== e.memory_accessed)
            report_mismatch("memory_accessed", memory_accessed, e.memory_accessed);
          if (l1_victim_written_back !== e.victim_wb)
            report_mismatch("l1_victim_written_back", l1_victim_written_back, e.victim_wb);
        end
      end
    end
  end
endmodule

FILE: bench/testbench.sv
// Top of the cache model testbench: clock, reset, access stimulus, configuration phases
// and verdict. Depends on tllc_pkg, two_level_lru_cache_model_top and cache_access_checker.
`timescale 1ns / 1ps
module testbench;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        operation;
  logic [31:0] address;
  logic        out_valid;
  logic        out_stall;
  logic        l1_hit, l2_accessed, l2_hit, memory_accessed, l1_victim_written_back;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [3:0]  cfg_data;
  int          error_count;
  int          pending_count;
  int          cycle_count = 0;
  int          stall_left = 0;
  logic [31:0] recent_addr[$];

  two_level_lru_cache_model_top u_top (.*);

  cache_access_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int gap_length();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= gap_length();
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_access(logic wr, logic [31:0] addr, bit with_gaps);
    int g;
    g = with_gaps ? gap_length() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= wr;
    address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    recent_addr.insert(recent_addr.size(), addr);
    if (recent_addr.size() > 24) void'(recent_addr.pop_front());
  endtask

  task automatic write_reg(logic [2:0] idx, logic [3:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic random_phase(int count);
    logic [31:0] a;
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5 && recent_addr.size() > 0)
        a = recent_addr[$urandom_range(0, recent_addr.size() - 1)] ^ $urandom_range(0, 3);
      else if (pick < 8)
        a = {3'($urandom_range(0, 7)), 3'd0, 10'd0, 16'($urandom_range(0, 65535))};
      else a = $urandom;
      send_access(1'($urandom_range(0, 1)), a, k % 40 < 30);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = 1'b0;
    address = '0;
    cfg_write = 1'b0;
    cfg_index = tllc_pkg::REG_ALLOC_MODE;
    cfg_data = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_access(1'b0, 32'h0000_0000, 0);
    send_access(1'b0, 32'h0000_0000, 0);
    send_access(1'b1, 32'h0000_0000, 0);
    send_access(1'b1, 32'hFFFF_FFFF, 0);
    send_access(1'b0, 32'hFFFF_FFFF, 0);
    send_access(1'b1, 32'h5555_5555, 0);
    send_access(1'b1, 32'hAAAA_AAAA, 0);
    for (int k = 1; k <= 6; k++) send_access(1'b1, 32'(k) << 11, 0);
    drain();

    write_reg(tllc_pkg::REG_ALLOC_MODE, 4'd0);
    write_reg(tllc_pkg::REG_L1_WAYS_USED, 4'd0);
    write_reg(tllc_pkg::REG_L2_WAYS_USED, 4'd15);
    write_reg(tllc_pkg::REG_BLOCK_BITS, 4'd15);
    write_reg(tllc_pkg::REG_L1_SET_BITS, 4'd7);
    write_reg(tllc_pkg::REG_L2_SET_BITS, 4'd15);
    send_access(1'b1, 32'h0000_0000, 0);
    send_access(1'b1, 32'h1234_0000, 0);
    send_access(1'b0, 32'h0000_8000, 0);
    send_access(1'b1, 32'h0000_8000, 0);
    send_access(1'b0, 32'hFFFF_0000, 0);
    random_phase(60);
    drain();

    write_reg(tllc_pkg::REG_ALLOC_MODE, 4'd1);
    write_reg(tllc_pkg::REG_BLOCK_BITS, 4'd0);
    write_reg(tllc_pkg::REG_L1_SET_BITS, 4'd0);
    write_reg(tllc_pkg::REG_L1_WAYS_USED, 4'd2);
    write_reg(tllc_pkg::REG_L2_SET_BITS, 4'd0);
    write_reg(tllc_pkg::REG_L2_WAYS_USED, 4'd3);
    random_phase(120);
    drain();

    write_reg(tllc_pkg::REG_BLOCK_BITS, 4'd8);
    write_reg(tllc_pkg::REG_L1_SET_BITS, 4'd2);
    write_reg(tllc_pkg::REG_L1_WAYS_USED, 4'd7);
    write_reg(tllc_pkg::REG_L2_SET_BITS, 4'd3);
    write_reg(tllc_pkg::REG_L2_WAYS_USED, 4'd0);
    random_phase(100);
    drain();

    write_reg(tllc_pkg::REG_ALLOC_MODE, 4'd0);
    write_reg(tllc_pkg::REG_BLOCK_BITS, 4'd2);
    write_reg(tllc_pkg::REG_L1_SET_BITS, 4'd1);
    write_reg(tllc_pkg::REG_L1_WAYS_USED, 4'd4);
    write_reg(tllc_pkg::REG_L2_SET_BITS, 4'd2);
    write_reg(tllc_pkg::REG_L2_WAYS_USED, 4'd8);
    random_phase(100);
    drain();

    write_reg(tllc_pkg::REG_ALLOC_MODE, 4'd1);
    write_reg(tllc_pkg::REG_BLOCK_BITS, 4'd5);
    write_reg(tllc_pkg::REG_L1_SET_BITS, 4'd6);
    write_reg(tllc_pkg::REG_L2_SET_BITS, 4'd8);
    random_phase(100);
    drain();

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
